// File: rtl/dual_channel_moving_average_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual channel moving average
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_DEFINES_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTH
`define DCMA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcma assertion failed");
`define DCMA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcma assertion failed");
`else
`define DCMA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DCMA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/dcma_pkg.sv
// ----------------------------------------------------------------------------
// dcma_pkg
// Shared widths, controller states and command/status groups.
// ----------------------------------------------------------------------------
package dcma_pkg;

  localparam int RAW_W    = 10;
  localparam int SAMPLE_W = 8;
  localparam int HELD_W   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic idle;
    logic rd;
    logic div_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic rd_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/dcma_in_if.sv
// ----------------------------------------------------------------------------
// dcma_in_if
// Sample channel: one pair of raw converter results per transaction.
// ----------------------------------------------------------------------------
interface dcma_in_if;
  logic                       valid;
  logic                       ready;
  logic [dcma_pkg::RAW_W-1:0] vin_raw;
  logic [dcma_pkg::RAW_W-1:0] vups_raw;

  modport source (output valid, output vin_raw, output vups_raw, input ready);
  modport sink (input valid, input vin_raw, input vups_raw, output ready);
endinterface

// File: rtl/dcma_out_if.sv
// ----------------------------------------------------------------------------
// dcma_out_if
// Result channel: two averages and the sample count per transaction.
// ----------------------------------------------------------------------------
interface dcma_out_if;
  logic                          valid;
  logic                          ready;
  logic [dcma_pkg::SAMPLE_W-1:0] vin_average;
  logic [dcma_pkg::SAMPLE_W-1:0] vups_average;
  logic [dcma_pkg::HELD_W-1:0]   samples_held;

  modport source (output valid, output vin_average, output vups_average,
                  output samples_held, input ready);
  modport sink (input valid, input vin_average, input vups_average,
                input samples_held, output ready);
endinterface

// File: rtl/dual_channel_moving_average.sv
// ----------------------------------------------------------------------------
// dual_channel_moving_average
// Floor average of the last DEPTH samples (all samples so far while the ring fills) on two converter channels.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one pair of 10-bit results (vin_raw, vups_raw) per
//   transaction; the two low bits of each are dropped before storage.
//   result_ch returns one transaction per sample: both channel averages
//   over the filled ring entries and samples_held, the count averaged.
// Sequence:
//   The sequencer reads the shared ring RAM once per filled entry, then
//   runs two restoring dividers one quotient bit per cycle. A new
//   sample is taken only once the previous result has been loaded
//   into the output register.
// Reset:
//   Clears the write position, the fill count and all handshake state.
//   Ring contents are not cleared; only written entries are ever read.
// Backpressure:
//   The result register holds until taken. The next sample is still
//   accepted and processed; the block waits before loading a new result.
// ----------------------------------------------------------------------------
module dual_channel_moving_average #(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  dcma_in_if.sink    sample_ch,
  dcma_out_if.source result_ch
);

  dcma_pkg::cmd_t cmd;
  dcma_pkg::sts_t sts;

  dcma_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  dcma_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: rtl/dcma_ram.sv
// ----------------------------------------------------------------------------
// dcma_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dcma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dcma_ctrl.sv
// ----------------------------------------------------------------------------
// dcma_ctrl
// Sequencer: accept, sum the filled entries, divide, hand off the result.
// ----------------------------------------------------------------------------
module dcma_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  dcma_pkg::sts_t sts,
  output dcma_pkg::cmd_t cmd
);

  dcma_pkg::state_t state;
  dcma_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dcma_pkg::ST_IDLE: begin
        if (sts.in_valid) state_next = dcma_pkg::ST_SUM;
      end
      dcma_pkg::ST_SUM: begin
        if (sts.rd_last) state_next = dcma_pkg::ST_DRAIN;
      end
      dcma_pkg::ST_DRAIN: begin
        state_next = dcma_pkg::ST_DIV;
      end
      dcma_pkg::ST_DIV: begin
        if (sts.div_last) state_next = dcma_pkg::ST_LOAD;
      end
      dcma_pkg::ST_LOAD: begin
        if (sts.out_free) state_next = dcma_pkg::ST_IDLE;
      end
      default: begin
        state_next = dcma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      dcma_pkg::ST_IDLE:  cmd.idle     = 1'b1;
      dcma_pkg::ST_SUM:   cmd.rd       = 1'b1;
      dcma_pkg::ST_DRAIN: cmd.div_load = 1'b1;
      dcma_pkg::ST_DIV:   cmd.div_step = 1'b1;
      dcma_pkg::ST_LOAD:  cmd.load_out = sts.out_free;
      default:            cmd          = '0;
    endcase
  end

endmodule

// File: rtl/dcma_datapath.sv
// ----------------------------------------------------------------------------
// dcma_datapath
// Sample ring, position and fill count, summing, restoring dividers and
// the output register.
// ----------------------------------------------------------------------------
`include "dual_channel_moving_average_defines.svh"

module dcma_datapath #(
  parameter int DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  dcma_in_if.sink        sample_ch,
  dcma_out_if.source     result_ch,
  input  dcma_pkg::cmd_t cmd,
  output dcma_pkg::sts_t sts
);

  localparam int AW  = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = $clog2(DEPTH * 255 + 1);
  localparam int KW  = $clog2(SW);
  localparam int DW  = 2 * dcma_pkg::SAMPLE_W;
  localparam int SMW = dcma_pkg::SAMPLE_W;

  logic [AW-1:0] wpos;
  logic [CW-1:0] fill;
  logic [CW-1:0] rd_idx;
  logic          rd_pend;
  logic [DW-1:0] rdata;
  logic          accept;

  logic [SW-1:0] acc     [2];
  logic [SW-1:0] acc_fin [2];
  logic [SW-1:0] dvd     [2];
  logic [SW-1:0] dvd_next[2];
  logic [CW-1:0] rem     [2];
  logic [CW-1:0] rem_next[2];
  logic [KW-1:0] step_cnt;
  logic          out_valid;

  // hold off the sender while reset is applied
  assign sample_ch.ready = cmd.idle & !rst;
  assign accept          = sample_ch.ready & sample_ch.valid;

  dcma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wpos),
    .wdata ({sample_ch.vin_raw[dcma_pkg::RAW_W-1:2],
             sample_ch.vups_raw[dcma_pkg::RAW_W-1:2]}),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // position, fill count and read sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos    <= '0;
      fill    <= '0;
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
      if (accept) begin
        wpos   <= (wpos == AW'(DEPTH - 1)) ? '0 : wpos + AW'(1);
        rd_idx <= '0;
        if (fill != CW'(DEPTH)) fill <= fill + CW'(1);
      end else if (cmd.rd) begin
        rd_idx <= rd_idx + CW'(1);
      end
    end
  end

  always_comb begin
    acc_fin[0] = acc[0] + (rd_pend ? SW'(rdata[DW-1:SMW]) : '0);
    acc_fin[1] = acc[1] + (rd_pend ? SW'(rdata[SMW-1:0]) : '0);
  end

  // one restoring step per cycle: shift a dividend bit into the remainder
  always_comb begin
    logic [CW:0] trial;
    for (int c = 0; c < 2; c++) begin
      trial = {rem[c], dvd[c][SW-1]};
      if (trial >= {1'b0, fill}) begin
        rem_next[c] = CW'(trial - {1'b0, fill});
        dvd_next[c] = {dvd[c][SW-2:0], 1'b1};
      end else begin
        rem_next[c] = trial[CW-1:0];
        dvd_next[c] = {dvd[c][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc[0] <= '0;
      acc[1] <= '0;
    end else if (rd_pend) begin
      acc[0] <= acc_fin[0];
      acc[1] <= acc_fin[1];
    end
    if (cmd.div_load) begin
      dvd[0]   <= acc_fin[0];
      dvd[1]   <= acc_fin[1];
      rem[0]   <= '0;
      rem[1]   <= '0;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      dvd[0]   <= dvd_next[0];
      dvd[1]   <= dvd_next[1];
      rem[0]   <= rem_next[0];
      rem[1]   <= rem_next[1];
      step_cnt <= step_cnt + KW'(1);
    end
  end

  // output register, holds until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_ch.vin_average  <= dvd[0][SMW-1:0];
      result_ch.vups_average <= dvd[1][SMW-1:0];
      result_ch.samples_held <= dcma_pkg::HELD_W'(fill);
    end
  end

  assign result_ch.valid = out_valid;

  always_comb begin
    sts.in_valid = sample_ch.valid;
    sts.rd_last  = (rd_idx + CW'(1)) == fill;
    sts.div_last = step_cnt == KW'(SW - 1);
    sts.out_free = !out_valid || result_ch.ready;
  end

  `DCMA_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CW'(DEPTH))
  `DCMA_ASSERT_IMP(a_rd_in_fill, clk, rst, cmd.rd, rd_idx < fill)
  `DCMA_ASSERT_IMP(a_load_free, clk, rst, cmd.load_out, !out_valid || result_ch.ready)
  `DCMA_ASSERT_NXT(a_load_valid, clk, rst, cmd.load_out, out_valid)

endmodule
